// ===== rtl/kdh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdh_pkg: shared constants for the key debouncer and report generator
// Key byte width, settle counter width, idle step and report key codes.
// ----------------------------------------------------------------------------
package kdh_pkg;

  // Width of the key port and of every key byte.
  localparam int unsigned KEY_W = 8;

  // Width of the settle counter and of the settle threshold.
  localparam int unsigned SETTLE_W = 4;

  // Width of the report key codes.
  localparam int unsigned CODE_W = 8;

  // Key codes that are reported for debounced bits 0, 1 and 2.
  localparam logic [CODE_W-1:0] KEY_CODE_BIT0 = 8'd64;
  localparam logic [CODE_W-1:0] KEY_CODE_BIT1 = 8'd66;
  localparam logic [CODE_W-1:0] KEY_CODE_BIT2 = 8'd73;
  localparam logic [CODE_W-1:0] KEY_CODE_NONE = 8'd0;

  // Amount the idle counter steps down on each timer tick.
  localparam logic [KEY_W-1:0] IDLE_STEP = 8'd5;

  // Debouncer state as seen by the report logic.
  typedef struct packed {
    logic [KEY_W-1:0] debounced_next;
  } kdh_deb_status_t;

endpackage

// ===== rtl/kdh_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdh_debounce: key port debouncer
// Inverts the active-low sample and accepts a new key byte once it has
// repeated on SETTLE_COUNT further polls.
// ----------------------------------------------------------------------------
module kdh_debounce import kdh_pkg::*; #(
  parameter int unsigned SETTLE_COUNT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [KEY_W-1:0]     port_sample_i,
  output kdh_deb_status_t      status_o
);

  localparam logic [SETTLE_W-1:0] SettleLimit = SETTLE_W'(SETTLE_COUNT);

  logic [KEY_W-1:0]    candidate_q, candidate_d;
  logic [SETTLE_W-1:0] settle_q, settle_d;
  logic [KEY_W-1:0]    debounced_q, debounced_d;
  logic [KEY_W-1:0]    sample_now;

  // Next debouncer state for the polled sample.
  always_comb begin
    sample_now  = ~port_sample_i;
    candidate_d = candidate_q;
    settle_d    = settle_q;
    debounced_d = debounced_q;
    if (sample_now != candidate_q) begin
      candidate_d = sample_now;
      settle_d    = '0;
    end else if (candidate_q != debounced_q) begin
      settle_d = settle_q + SETTLE_W'(1);
      if (settle_d == SettleLimit) begin
        debounced_d = candidate_q;
      end
    end
  end

  // State advances only when a poll is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      candidate_q <= '0;
      settle_q    <= '0;
      debounced_q <= '0;
    end else if (step_i) begin
      candidate_q <= candidate_d;
      settle_q    <= settle_d;
      debounced_q <= debounced_d;
    end
  end

  assign status_o.debounced_next = debounced_d;

endmodule

// ===== rtl/key_debounce_hid_report.sv =====
`timescale 1ns / 1ps
// A result is registered in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register is refilled
// in the same cycle it is taken, so the rate is set only by the downstream.
// Reset: asynchronous, active low; all debounce, report and idle state and
// the idle rate clear to zero, and the result register is emptied.
// ----------------------------------------------------------------------------
// key_debounce_hid_report: debounced key port with HID idle-rate reports
// Debounces an 8-bit key port poll, runs the idle repeat counter and
// builds a three-slot key report whenever one is due.
// ----------------------------------------------------------------------------
module key_debounce_hid_report import kdh_pkg::*; #(
  parameter int unsigned SETTLE_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [KEY_W-1:0]  idle_rate_i,
  // Poll request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KEY_W-1:0]  port_sample_i,
  input  logic              timer_tick_i,
  input  logic              endpoint_ready_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              report_valid_o,
  output logic [CODE_W-1:0] key_slot_a_o,
  output logic [CODE_W-1:0] key_slot_b_o,
  output logic [CODE_W-1:0] key_slot_c_o,
  output logic [KEY_W-1:0]  stable_keys_o
);

  logic              in_accept;
  kdh_deb_status_t   deb_status;
  logic [KEY_W-1:0]  idle_rate_q;
  logic [KEY_W-1:0]  idle_count_q, idle_count_d;
  logic              pending_q, pending_d, pending_tick;
  logic [KEY_W-1:0]  reported_q, reported_d;
  logic [KEY_W-1:0]  deb_keys;
  logic              send;
  logic [CODE_W-1:0] slot_a, slot_b, slot_c;
  logic              out_valid_q;
  logic              report_q;
  logic [CODE_W-1:0] slot_a_q, slot_b_q, slot_c_q;
  logic [KEY_W-1:0]  stable_q;

  // A request is taken whenever the result register is empty or draining.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  kdh_debounce #(
    .SETTLE_COUNT (SETTLE_COUNT)
  ) u_debounce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_accept),
    .port_sample_i (port_sample_i),
    .status_o      (deb_status)
  );

  assign deb_keys = deb_status.debounced_next;

  // Idle repeat counter: while the idle rate is nonzero, step down on a tick, or reload and ask for a report.
  always_comb begin
    idle_count_d = idle_count_q;
    pending_tick = pending_q;
    if (timer_tick_i && (idle_rate_q != '0)) begin
      if (idle_count_q >= IDLE_STEP) begin
        idle_count_d = idle_count_q - IDLE_STEP;
      end else begin
        idle_count_d = idle_rate_q;
        pending_tick = 1'b1;
      end
    end
  end

  // Report decision and packing of key codes for bits 0, 1 and 2.
  always_comb begin
    send       = endpoint_ready_i && ((deb_keys != reported_q) || pending_tick);
    reported_d = send ? deb_keys : reported_q;
    pending_d  = send ? 1'b0 : pending_tick;
    slot_a     = KEY_CODE_NONE;
    slot_b     = KEY_CODE_NONE;
    slot_c     = KEY_CODE_NONE;
    if (send) begin
      if (deb_keys[0]) begin
        slot_a = KEY_CODE_BIT0;
        if (deb_keys[1]) begin
          slot_b = KEY_CODE_BIT1;
          if (deb_keys[2]) begin
            slot_c = KEY_CODE_BIT2;
          end
        end else if (deb_keys[2]) begin
          slot_b = KEY_CODE_BIT2;
        end
      end else if (deb_keys[1]) begin
        slot_a = KEY_CODE_BIT1;
        if (deb_keys[2]) begin
          slot_b = KEY_CODE_BIT2;
        end
      end else if (deb_keys[2]) begin
        slot_a = KEY_CODE_BIT2;
      end
    end
  end

  // Configuration register; the idle counter keeps its value on a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_rate_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      idle_rate_q <= idle_rate_i;
    end
  end

  // Report and idle state advance once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_count_q <= '0;
      pending_q    <= 1'b0;
      reported_q   <= '0;
    end else if (in_accept) begin
      idle_count_q <= idle_count_d;
      pending_q    <= pending_d;
      reported_q   <= reported_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      report_q <= send;
      slot_a_q <= slot_a;
      slot_b_q <= slot_b;
      slot_c_q <= slot_c;
      stable_q <= deb_keys;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign report_valid_o = report_q;
  assign key_slot_a_o   = slot_a_q;
  assign key_slot_b_o   = slot_b_q;
  assign key_slot_c_o   = slot_c_q;
  assign stable_keys_o  = stable_q;

endmodule
